FILE: rtl/core/llqfp_pkg.sv
// ============================================================================
// llqfp_pkg - shared types and codes for the linked-list queue
// Status codes, operation codes and the bundles passed between the
// control block and the top level.
// ============================================================================
package llqfp_pkg;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	// operation codes on the action input
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	// node store strobes issued by the control block
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_cmd_t;

	// registered result word (value comes from the store read port)
	typedef struct packed {
		logic                valid;
		logic                take;
		logic [STATUS_W-1:0] status;
		logic                now_empty;
	} res_t;

endpackage

FILE: rtl/core/llqfp_ram.sv
// ============================================================================
// llqfp_ram - node value store
// One write port and one read port, read data registered.
// ============================================================================
module llqfp_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                                clk,
	input  llqfp_pkg::mem_cmd_t                 cmd,
	input  logic [AW-1:0]                       waddr,
	input  logic [llqfp_pkg::VALUE_W-1:0]       wdata,
	input  logic [AW-1:0]                       raddr,
	output logic [llqfp_pkg::VALUE_W-1:0]       rdata
);

	logic [llqfp_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/llqfp_ctrl.sv
// ============================================================================
// llqfp_ctrl - queue pointers, occupancy and result status
// Decides each word in one pass from the registered pointers and count,
// issues the node store access and registers the result flags.
// ============================================================================
module llqfp_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                action,
	output llqfp_pkg::mem_cmd_t cmd,
	output logic [AW-1:0]       waddr,
	output logic [AW-1:0]       raddr,
	output llqfp_pkg::res_t     res_s1
);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic          full;
	logic          empty;
	logic          is_ins;
	llqfp_pkg::res_t res_d;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign is_ins = (action == llqfp_pkg::ACT_INSERT);

	assign cmd.wr = accept && is_ins && !full;
	assign cmd.rd = accept && !is_ins && !empty;
	assign waddr  = wr_ptr_q;
	assign raddr  = rd_ptr_q;

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.wr) begin
			cnt_d = cnt_q + CW'(1);
		end else if (cmd.rd) begin
			cnt_d = cnt_q - CW'(1);
		end
	end

	always_comb begin
		res_d.valid     = accept;
		res_d.take      = cmd.rd;
		res_d.now_empty = (cnt_d == '0);
		priority if (is_ins && full) begin
			res_d.status = llqfp_pkg::ST_OVERFLOW;
		end else if (!is_ins && empty) begin
			res_d.status = llqfp_pkg::ST_UNDERFLOW;
		end else begin
			res_d.status = llqfp_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			res_s1   <= '0;
		end else begin
			cnt_q  <= cnt_d;
			res_s1 <= res_d;
			if (cmd.wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (cmd.rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
		end
	end

endmodule

FILE: rtl/core/linked_list_queue_free_pool.sv
// ============================================================================
// linked_list_queue_free_pool - FIFO queue over a fixed pool of DEPTH nodes
// Insert at tail, remove from head, with overflow/underflow reporting.
// ============================================================================
// Usage:
//   Command channel: drive action/value with start high. A word is taken
//   at any rising edge where start is high and busy is low; busy never
//   rises, so one word can be taken every cycle.
//   Result channel: exactly one result per word, shown for one cycle with
//   strobe high, in the cycle after the word is taken (throughput 1 word
//   per cycle). The receiver cannot stall; results must be taken.
//   Insert: stores value in the next free node; status overflow and no
//     change when all DEPTH nodes hold data. removed_value is 0.
//   Remove: returns the oldest value and frees its node; status underflow,
//     removed_value 0 and no change when the queue is empty.
//   now_empty reports the queue state after the word.
//   Nodes are allocated and freed in ring order, so the free pool is a
//   pointer pair plus an occupancy count; the node value store is a
//   single-port-write, single-port-read memory with a registered read.
//   Reset (arst_n low) empties the queue at once; no clearing pass.
// ============================================================================
module linked_list_queue_free_pool #(
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 action,
	input  logic signed [llqfp_pkg::VALUE_W-1:0] value,
	output logic                                 strobe,
	output logic signed [llqfp_pkg::VALUE_W-1:0] removed_value,
	output logic [llqfp_pkg::STATUS_W-1:0]       status,
	output logic                                 now_empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                            accept;
	llqfp_pkg::mem_cmd_t             cmd;
	logic [AW-1:0]                   waddr;
	logic [AW-1:0]                   raddr;
	logic [llqfp_pkg::VALUE_W-1:0]   rdata;
	llqfp_pkg::res_t                 res_s1;

	// single pass, no back-pressure on the command side
	assign busy   = 1'b0;
	assign accept = start && !busy;

	llqfp_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.action (action),
		.cmd    (cmd),
		.waddr  (waddr),
		.raddr  (raddr),
		.res_s1 (res_s1)
	);

	llqfp_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.cmd   (cmd),
		.waddr (waddr),
		.wdata (value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result word: flags from the control register, value from the read port
	assign strobe        = res_s1.valid;
	assign status        = res_s1.status;
	assign now_empty     = res_s1.now_empty;
	assign removed_value = res_s1.take ? rdata : '0;

endmodule

FILE: rtl/core/llqfp_chk.sv
// ============================================================================
// llqfp_chk - port-level checks for the queue
// Result timing and status consistency as seen on the top-level ports.
// ============================================================================
module llqfp_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 action,
	input logic                                 strobe,
	input logic signed [llqfp_pkg::VALUE_W-1:0] removed_value,
	input logic [llqfp_pkg::STATUS_W-1:0]       status,
	input logic                                 now_empty
);

	// every taken word gives one result on the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> strobe)
		else $error("no result after accepted word");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !strobe)
		else $error("result without accepted word");

	// an insert never returns a value and never underflows
	a_insert_res: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == llqfp_pkg::ACT_INSERT) |=>
		(removed_value == '0 && status != llqfp_pkg::ST_UNDERFLOW))
		else $error("bad insert result");

	// underflow leaves the queue empty, overflow leaves it full (checked as not empty)
	a_status_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == llqfp_pkg::ST_UNDERFLOW) |->
		(now_empty && removed_value == '0))
		else $error("underflow result inconsistent");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == llqfp_pkg::ST_OVERFLOW) |-> !now_empty)
		else $error("overflow reported on empty queue");

endmodule

bind linked_list_queue_free_pool llqfp_chk u_llqfp_chk (.*);
